// File: hdl/pgvp_pkg.sv
package pgvp_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = COL_W + 1;
  localparam int ROW_W    = 16;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(1024);
  localparam logic [31:0]      SOD_RESET  = 32'h0001_0000;

  typedef enum logic [1:0] {
    REG_COLUMN_COUNT = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_STEP_DENSITY = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_DIV_LD,
    S_DIV,
    S_DIV_END,
    S_MUL_LD,
    S_MUL_FIN,
    S_WR,
    S_OUT0,
    S_OUT1
  } state_t;

  // one column of the line store
  typedef struct packed {
    logic [31:0] pressure;
    logic [31:0] older;
    logic [31:0] mid_u;
    logic [31:0] mid_v;
    logic        fixed;
    logic [31:0] fixed_u;
    logic [31:0] fixed_v;
    logic [31:0] xpos;
  } line_t;

endpackage

// File: hdl/pressure_gradient_velocity_projection.sv
// Velocity correction over a streamed grid in raster order. Each request brings one cell;
// it emits the result of the cell one row above (none on the first row), and on the last
// row also the cell's own prescribed velocity. A request is taken only when the block is
// idle. Every cell takes three line store reads and one write; a cell that is not on the
// first row, not on the border and not fixed also passes the 48-step restoring divider,
// which computes the four pressure slopes one after another, and two multiplies on a
// shared 33x33 multiplier. A cell that emits a result also waits for it to be taken.
// The line store is one memory of one entry per column.
module pressure_gradient_velocity_projection (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pressure, mid_u, mid_v, fixed_u, fixed_v, x_coord, y_coord
  input  logic [223:0] in_tdata,
  // is_fixed
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_col, out_row, new_u, new_v, zero pad
  output logic [95:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = pgvp_pkg::COL_W;
  localparam int NW = pgvp_pkg::CNT_W;
  localparam int RW = pgvp_pkg::ROW_W;

  pgvp_pkg::state_t state_r, state_nxt;

  logic [NW-1:0] col_count_r;
  logic [RW-1:0] row_count_r;
  logic [31:0]   sod_r;

  logic [CW-1:0] col_ctr_r;
  logic [RW-1:0] row_ctr_r;
  logic [31:0]   y_hist_r [3];

  logic [NW-1:0] cols_w;
  logic [RW-1:0] rows_w;
  logic [CW-1:0] c_w;
  logic [RW-1:0] r_w;

  logic [NW-1:0] cols_r;
  logic [RW-1:0] rows_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;

  logic [31:0] p_r, mu_r, mv_r, fu_r, fv_r, xc_r;
  logic        fx_r;

  pgvp_pkg::line_t ent_l_r, ent_m_r, ent_r_r, rd_ent, wr_ent;

  logic          ram_we;
  logic [CW-1:0] ram_raddr;
  logic [$bits(pgvp_pkg::line_t)-1:0] ram_rdata;

  logic [1:0]  k_r;
  logic        j_r;
  logic [31:0] slope_r [4];

  logic [47:0] num_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic        qneg_r, dzero_r, dpneg_r, dpzero_r;
  logic [pgvp_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic signed [65:0] prod_r;
  logic [31:0] new_u_r, new_v_r;

  logic        out_valid_r, out_last_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic [31:0] out_u_r, out_v_r;

  logic accept;
  logic border_w;
  logic last_row_w;

  // clamped counts and current position
  always_comb begin
    if (col_count_r < NW'(3)) begin
      cols_w = NW'(3);
    end else if (col_count_r > NW'(pgvp_pkg::MAX_COLS)) begin
      cols_w = NW'(pgvp_pkg::MAX_COLS);
    end else begin
      cols_w = col_count_r;
    end
    rows_w = (row_count_r < RW'(3)) ? RW'(3) : row_count_r;
    c_w = ({1'b0, col_ctr_r} < cols_w) ? col_ctr_r : CW'(cols_w - NW'(1));
    r_w = (row_ctr_r < rows_w) ? row_ctr_r : rows_w - RW'(1);
  end

  assign accept     = in_tvalid && in_tready;
  assign last_row_w = (r_r == rows_r - RW'(1));
  assign border_w   = (r_r == RW'(1)) || ((r_r - RW'(1)) >= (rows_r - RW'(1))) ||
                      (c_r == '0) || ({1'b0, c_r} >= (cols_r - NW'(1)));

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= pgvp_pkg::COLS_RESET;
      row_count_r <= pgvp_pkg::ROWS_RESET;
      sod_r       <= pgvp_pkg::SOD_RESET;
    end else if (cfg_valid) begin
      case (pgvp_pkg::reg_index_t'(cfg_index))
        pgvp_pkg::REG_COLUMN_COUNT: col_count_r <= cfg_data[NW-1:0];
        pgvp_pkg::REG_ROW_COUNT:    row_count_r <= cfg_data[RW-1:0];
        pgvp_pkg::REG_STEP_DENSITY: sod_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // line store
  assign rd_ent = pgvp_pkg::line_t'(ram_rdata);

  always_comb begin
    wr_ent.pressure = p_r;
    wr_ent.older    = ent_m_r.pressure;
    wr_ent.mid_u    = mu_r;
    wr_ent.mid_v    = mv_r;
    wr_ent.fixed    = fx_r;
    wr_ent.fixed_u  = fu_r;
    wr_ent.fixed_v  = fv_r;
    wr_ent.xpos     = xc_r;
  end

  pgvp_ram #(
    .WIDTH($bits(pgvp_pkg::line_t)),
    .DEPTH(pgvp_pkg::MAX_COLS)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(c_r),
    .wdata(wr_ent),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgvp_pkg::S_IDLE:    if (accept) state_nxt = pgvp_pkg::S_RD0;
      pgvp_pkg::S_RD0:     state_nxt = pgvp_pkg::S_RD1;
      pgvp_pkg::S_RD1:     state_nxt = pgvp_pkg::S_RD2;
      pgvp_pkg::S_RD2:     state_nxt = pgvp_pkg::S_RD3;
      pgvp_pkg::S_RD3: begin
        if (r_r == '0 || border_w || ent_m_r.fixed) begin
          state_nxt = pgvp_pkg::S_WR;
        end else begin
          state_nxt = pgvp_pkg::S_DIV_LD;
        end
      end
      pgvp_pkg::S_DIV_LD:  state_nxt = pgvp_pkg::S_DIV;
      pgvp_pkg::S_DIV:     if (div_cnt_r == '0) state_nxt = pgvp_pkg::S_DIV_END;
      pgvp_pkg::S_DIV_END: begin
        state_nxt = (k_r == 2'd3) ? pgvp_pkg::S_MUL_LD : pgvp_pkg::S_DIV_LD;
      end
      pgvp_pkg::S_MUL_LD:  state_nxt = pgvp_pkg::S_MUL_FIN;
      pgvp_pkg::S_MUL_FIN: state_nxt = j_r ? pgvp_pkg::S_WR : pgvp_pkg::S_MUL_LD;
      pgvp_pkg::S_WR: begin
        if (r_r != '0) begin
          state_nxt = pgvp_pkg::S_OUT0;
        end else if (last_row_w) begin
          state_nxt = pgvp_pkg::S_OUT1;
        end else begin
          state_nxt = pgvp_pkg::S_IDLE;
        end
      end
      pgvp_pkg::S_OUT0: begin
        if (out_tready) state_nxt = last_row_w ? pgvp_pkg::S_OUT1 : pgvp_pkg::S_IDLE;
      end
      pgvp_pkg::S_OUT1:    if (out_tready) state_nxt = pgvp_pkg::S_IDLE;
      default:             state_nxt = pgvp_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = c_r;
    case (state_r)
      pgvp_pkg::S_IDLE: in_tready = 1'b1;
      pgvp_pkg::S_RD0:  ram_raddr = c_r - CW'(1);
      pgvp_pkg::S_RD1:  ram_raddr = c_r;
      pgvp_pkg::S_RD2:  ram_raddr = c_r + CW'(1);
      pgvp_pkg::S_WR:   ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgvp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture, counters and row y history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_ctr_r   <= '0;
      row_ctr_r   <= '0;
      y_hist_r[0] <= '0;
      y_hist_r[1] <= '0;
      y_hist_r[2] <= '0;
    end else begin
      if (accept && c_w == '0) begin
        y_hist_r[2] <= y_hist_r[1];
        y_hist_r[1] <= y_hist_r[0];
        y_hist_r[0] <= in_tdata[223:192];
      end
      if (ram_we) begin
        if (({1'b0, c_r} + NW'(1)) >= cols_r) begin
          col_ctr_r <= '0;
          row_ctr_r <= (({1'b0, r_r} + 17'd1) >= {1'b0, rows_r}) ? '0 : r_r + RW'(1);
        end else begin
          col_ctr_r <= c_r + CW'(1);
          row_ctr_r <= r_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r    <= in_tdata[31:0];
      mu_r   <= in_tdata[63:32];
      mv_r   <= in_tdata[95:64];
      fu_r   <= in_tdata[127:96];
      fv_r   <= in_tdata[159:128];
      xc_r   <= in_tdata[191:160];
      fx_r   <= in_tuser[0];
      cols_r <= cols_w;
      rows_r <= rows_w;
      c_r    <= c_w;
      r_r    <= r_w;
    end
    if (state_r == pgvp_pkg::S_RD1) ent_l_r <= rd_ent;
    if (state_r == pgvp_pkg::S_RD2) ent_m_r <= rd_ent;
    if (state_r == pgvp_pkg::S_RD3) ent_r_r <= rd_ent;
  end

  // slope operands picked by k_r
  logic [31:0] op_a, op_b, op_sa, op_sb;
  logic [32:0] dp_w, ds_w, dp_mag, ds_mag;

  always_comb begin
    case (k_r)
      2'd0: begin
        op_a = ent_r_r.pressure; op_b = ent_m_r.pressure;
        op_sa = ent_r_r.xpos;    op_sb = ent_m_r.xpos;
      end
      2'd1: begin
        op_a = ent_m_r.pressure; op_b = ent_l_r.older;
        op_sa = ent_m_r.xpos;    op_sb = ent_l_r.xpos;
      end
      2'd2: begin
        op_a = p_r;           op_b = ent_m_r.pressure;
        op_sa = y_hist_r[0];  op_sb = y_hist_r[1];
      end
      default: begin
        op_a = ent_m_r.pressure; op_b = ent_m_r.older;
        op_sa = y_hist_r[1];     op_sb = y_hist_r[2];
      end
    endcase
    dp_w   = {op_a[31], op_a} - {op_b[31], op_b};
    ds_w   = {op_sa[31], op_sa} - {op_sb[31], op_sb};
    dp_mag = dp_w[32] ? (33'd0 - dp_w) : dp_w;
    ds_mag = ds_w[32] ? (33'd0 - ds_w) : ds_w;
  end

  // restoring divider step
  logic [32:0] rem_sh;
  logic [33:0] rem_diff;
  logic [31:0] slope_w;

  assign rem_sh   = {rem_r, num_r[47]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    if (dzero_r) begin
      if (dpzero_r) begin
        slope_w = '0;
      end else begin
        slope_w = dpneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end else if (!qneg_r) begin
      slope_w = (num_r > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : num_r[31:0];
    end else begin
      slope_w = (num_r > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - num_r[31:0]);
    end
  end

  // mean of the two slopes and the velocity update
  logic [32:0] sum_w, mean_w;
  logic signed [65:0] corr_w, diff_w, mid_w;
  logic [31:0] res_w;

  always_comb begin
    if (!j_r) begin
      sum_w = {slope_r[0][31], slope_r[0]} + {slope_r[1][31], slope_r[1]};
      mid_w = 66'($signed(ent_m_r.mid_u));
    end else begin
      sum_w = {slope_r[2][31], slope_r[2]} + {slope_r[3][31], slope_r[3]};
      mid_w = 66'($signed(ent_m_r.mid_v));
    end
    mean_w = 33'($signed(sum_w + {32'd0, sum_w[32]}) >>> 1);
    corr_w = $signed(prod_r + (prod_r[65] ? 66'sd65535 : 66'sd0)) >>> 16;
    diff_w = mid_w - corr_w;
    if (diff_w > 66'sd2147483647) begin
      res_w = 32'h7FFF_FFFF;
    end else if (diff_w < -66'sd2147483648) begin
      res_w = 32'h8000_0000;
    end else begin
      res_w = diff_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      j_r       <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      case (state_r)
        pgvp_pkg::S_RD3: begin
          k_r <= '0;
          j_r <= 1'b0;
        end
        pgvp_pkg::S_DIV_LD: div_cnt_r <= pgvp_pkg::DIV_CNT_W'(pgvp_pkg::DIV_STEPS - 1);
        pgvp_pkg::S_DIV:    div_cnt_r <= div_cnt_r - 1'b1;
        pgvp_pkg::S_DIV_END: k_r <= k_r + 2'd1;
        pgvp_pkg::S_MUL_FIN: j_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      pgvp_pkg::S_RD3: begin
        new_u_r <= ent_m_r.fixed_u;
        new_v_r <= ent_m_r.fixed_v;
      end
      pgvp_pkg::S_DIV_LD: begin
        num_r    <= {dp_mag[31:0], 16'd0};
        den_r    <= ds_mag[31:0];
        rem_r    <= '0;
        qneg_r   <= dp_w[32] ^ ds_w[32];
        dzero_r  <= (ds_w == '0);
        dpneg_r  <= dp_w[32];
        dpzero_r <= (dp_w == '0);
      end
      pgvp_pkg::S_DIV: begin
        if (!rem_diff[33]) begin
          rem_r <= rem_diff[31:0];
          num_r <= {num_r[46:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          num_r <= {num_r[46:0], 1'b0};
        end
      end
      pgvp_pkg::S_DIV_END: slope_r[k_r] <= slope_w;
      pgvp_pkg::S_MUL_LD:  prod_r <= $signed(mean_w) * $signed({1'b0, sod_r});
      pgvp_pkg::S_MUL_FIN: begin
        if (!j_r) new_u_r <= res_w;
        else      new_v_r <= res_w;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        pgvp_pkg::S_WR: out_valid_r <= (r_r != '0) || last_row_w;
        pgvp_pkg::S_OUT0: if (out_tready) out_valid_r <= last_row_w;
        pgvp_pkg::S_OUT1: if (out_tready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == pgvp_pkg::S_WR && r_r != '0)) begin
      out_col_r  <= c_r;
      out_row_r  <= r_r - RW'(1);
      out_u_r    <= new_u_r;
      out_v_r    <= new_v_r;
      out_last_r <= !last_row_w;
    end else if ((state_r == pgvp_pkg::S_WR) ||
                 (state_r == pgvp_pkg::S_OUT0 && out_tready)) begin
      out_col_r  <= c_r;
      out_row_r  <= r_r;
      out_u_r    <= fu_r;
      out_v_r    <= fv_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_v_r, out_u_r, out_row_r, out_col_r};

`ifndef SYNTHESIS
  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == pgvp_pkg::S_OUT0 || state_r == pgvp_pkg::S_OUT1))
    else $error("result shown outside an output state");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("request taken while a result is pending");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgvp_pkg::S_DIV) |-> (div_cnt_r <= pgvp_pkg::DIV_CNT_W'(pgvp_pkg::DIV_STEPS - 1)))
    else $error("divider count out of range");
  a_wr_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == pgvp_pkg::S_OUT0 || state_r == pgvp_pkg::S_OUT1 ||
                state_r == pgvp_pkg::S_IDLE))
    else $error("line store write not followed by result or idle");
`endif

endmodule

// File: hdl/pgvp_ram.sv
module pgvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
